// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/isort_pkg.sv
package isort_pkg;

  // width of the key ports
  localparam int PORT_W = 32;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

// File: rtl/core/isort_ctrl.sv
module isort_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final_key,
  input  logic              out_stall,
  input  isort_pkg::stat_t  stat,
  output isort_pkg::cmd_t   cmd,
  output logic              in_stall,
  output logic              out_valid
);

  isort_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isort_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isort_pkg::ST_LOAD: begin
        if (in_valid && in_final_key) begin
          state_nxt = isort_pkg::ST_EMIT;
        end
      end
      isort_pkg::ST_EMIT: begin
        if (!out_stall && stat.last) begin
          state_nxt = isort_pkg::ST_LOAD;
        end
      end
      default: state_nxt = isort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      isort_pkg::ST_LOAD: begin
        in_stall   = 1'b0;
        cmd.insert = in_valid;
      end
      isort_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/isort_datapath.sv
`include "assert_macros.svh"

module isort_datapath #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  isort_pkg::cmd_t               cmd,
  input  logic [isort_pkg::PORT_W-1:0]  in_key,
  output isort_pkg::stat_t              stat,
  output logic [isort_pkg::PORT_W-1:0]  out_key,
  output logic                          out_ovf
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0] store_r   [DEPTH];
  logic [KEY_WIDTH-1:0] store_nxt [DEPTH];
  logic [KEY_WIDTH-1:0] below_key [DEPTH];
  logic [KEY_WIDTH-1:0] above_key [DEPTH];
  logic [DEPTH-1:0]     gt;
  logic [DEPTH-1:0]     below_gt;
  logic [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 full;

  // key narrowed or sign-extended to the store width
  if (KEY_WIDTH <= isort_pkg::PORT_W) begin : g_key_narrow
    assign key = in_key[KEY_WIDTH-1:0];
  end else begin : g_key_wide
    assign key = {{(KEY_WIDTH - isort_pkg::PORT_W){in_key[isort_pkg::PORT_W-1]}}, in_key};
  end

  // per-cell compare; empty cells count as greater
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= count_r) || ($signed(store_r[i]) > $signed(key));
    if (i == 0) begin : g_first
      assign below_key[i] = key;
      assign below_gt[i]  = 1'b0;
    end else begin : g_rest
      assign below_key[i] = store_r[i-1];
      assign below_gt[i]  = gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign above_key[i] = store_r[i];
    end else begin : g_mid
      assign above_key[i] = store_r[i+1];
    end
  end

  assign full = (count_r == CNT_W'(DEPTH));

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    priority if (cmd.insert) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (gt[i]) begin
            store_nxt[i] = below_gt[i] ? below_key[i] : key;
          end
        end
      end
    end else if (cmd.shift) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        ovf_nxt = 1'b0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        store_nxt[i] = above_key[i];
      end
    end else begin
      ovf_nxt = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign stat.last = (count_r == CNT_W'(1));
  assign out_ovf   = ovf_r;

  // head of the row, sign-extended or cut to the port width
  if (KEY_WIDTH >= isort_pkg::PORT_W) begin : g_out_cut
    assign out_key = store_r[0][isort_pkg::PORT_W-1:0];
  end else begin : g_out_ext
    assign out_key = {{(isort_pkg::PORT_W - KEY_WIDTH){store_r[0][KEY_WIDTH-1]}}, store_r[0]};
  end

  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_full_drop_sets_ovf, cmd.insert && full, ovf_r && full)

endmodule

// File: rtl/core/insertion_sorter.sv
// streaming stable insertion sorter. keys enter one per cycle while loading; each key is
// compared against every stored entry at once and dropped into place in that same cycle,
// larger entries moving up one place, equal keys keeping arrival order. the transaction
// flagged final_key is inserted and then closes the set: from the next cycle the stored keys
// leave in ascending order, one per cycle while out_stall is low, the last one marked
// end_of_run, while the input is stalled. the single output port reads the bottom of the
// shift row. keys beyond DEPTH are dropped and overflowed is high on every result of that
// set. no clearing pass after reset; the block takes keys from the first cycle out of
// reset.
`include "assert_macros.svh"

module insertion_sorter #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [isort_pkg::PORT_W-1:0]  in_key_value,
  input  logic                          in_final_key,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [isort_pkg::PORT_W-1:0]  out_sorted_key,
  output logic                          out_end_of_run,
  output logic                          out_overflowed
);

  isort_pkg::cmd_t  cmd;
  isort_pkg::stat_t stat;

  // sequencer: loading versus draining
  isort_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_final_key (in_final_key),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid)
  );

  // compare-and-shift register row with entry count and overflow flag
  isort_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_key  (in_key_value),
    .stat    (stat),
    .out_key (out_sorted_key),
    .out_ovf (out_overflowed)
  );

  // the head entry is the last one when a single key remains
  assign out_end_of_run = stat.last;

  // the closing key always leads to a drain phase
  `ASSERT_NEXT(a_final_starts_drain, in_valid && !in_stall && in_final_key, out_valid)
  // no key is taken while results are pending
  `ASSERT_IMPL(a_no_load_in_drain, out_valid, in_stall)
  // after the marked result the block is back to loading
  `ASSERT_NEXT(a_run_end_reloads, out_valid && !out_stall && out_end_of_run,
               !out_valid && !in_stall)

endmodule
